### rtl/rflp_pkg.sv
package rflp_pkg;

   localparam int RegWidth = 6;
   localparam int MaskWidth = 64;

   localparam logic [2:0] CMD_CLEAR        = 3'd0;
   localparam logic [2:0] CMD_ADMIT        = 3'd1;
   localparam logic [2:0] CMD_TAKE_FRONT   = 3'd2;
   localparam logic [2:0] CMD_TAKE_CALLER  = 3'd3;
   localparam logic [2:0] CMD_TAKE_CALLEE  = 3'd4;
   localparam logic [2:0] CMD_RELEASE      = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_EMPTY      = 3'd1;
   localparam logic [2:0] ST_INELIGIBLE = 3'd2;
   localparam logic [2:0] ST_DUPLICATE  = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;

   localparam logic [2:0] CSR_CALLEE_SAVED = 3'd0;
   localparam logic [2:0] CSR_GPR_ALLOC    = 3'd1;
   localparam logic [2:0] CSR_EXCLUDED     = 3'd2;
   localparam logic [2:0] CSR_SCRATCH_A    = 3'd3;
   localparam logic [2:0] CSR_SCRATCH_B    = 3'd4;

   localparam logic [1:0] MODE_FRONT  = 2'd0;
   localparam logic [1:0] MODE_CALLER = 2'd1;
   localparam logic [1:0] MODE_CALLEE = 2'd2;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_ADMIT,
      OP_TAKE,
      OP_RELEASE,
      OP_NONE
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [1:0]            mode;
      logic                  cls;
      logic [RegWidth-1:0]   reg_num;
   } op_type;

   typedef struct packed {
      logic [MaskWidth-1:0]  callee_saved;
      logic [MaskWidth-1:0]  gpr_alloc;
      logic [MaskWidth-1:0]  excluded;
      logic [RegWidth-1:0]   scratch_a;
      logic [RegWidth-1:0]   scratch_b;
   } cfg_type;

endpackage

### rtl/rflp_ram.sv
module rflp_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rflp_front.sv
module rflp_front
   import rflp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [3:0]  req_tuser,
   output logic        op_valid,
   input  logic        op_ready,
   output op_type      op
);

   op_type     q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   op_type     dec;
   logic       push;
   logic       pop;

   always_comb begin
      dec.cls     = req_tuser[3];
      dec.reg_num = req_tdata[RegWidth-1:0];
      dec.mode    = MODE_FRONT;
      case (req_tuser[2:0])
         CMD_CLEAR:       dec.kind = OP_CLEAR;
         CMD_ADMIT:       dec.kind = OP_ADMIT;
         CMD_TAKE_FRONT:  dec.kind = OP_TAKE;
         CMD_TAKE_CALLER: begin
            dec.kind = OP_TAKE;
            dec.mode = MODE_CALLER;
         end
         CMD_TAKE_CALLEE: begin
            dec.kind = OP_TAKE;
            dec.mode = MODE_CALLEE;
         end
         CMD_RELEASE:     dec.kind = OP_RELEASE;
         default:         dec.kind = OP_NONE;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign op_valid   = (cnt_ff != 2'd0);
   assign op         = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = op_valid && op_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

### rtl/rflp_back.sv
module rflp_back
   import rflp_pkg::*;
#(
   parameter int LIST_DEPTH = 64,
   parameter int REG_COUNT  = 64,
   parameter int FPR_BASE   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        op_valid,
   output logic        op_ready,
   input  op_type      op,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic [2:0]  rsp_tuser
);

   localparam int IW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int AW = IW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_CHK,
      S_SH_RD,
      S_SH_WR
   } state_type;

   state_type            state_ff;
   op_type               cur_ff;
   logic [IW-1:0]        idx_ff;
   logic [RegWidth-1:0]  first_ff;
   logic [RegWidth-1:0]  taken_ff;
   logic [CW-1:0]        gcount_ff;
   logic [CW-1:0]        fcount_ff;
   logic [MaskWidth-1:0] elig_ff;
   logic                 rsp_valid_ff;
   logic [RegWidth-1:0]  rsp_taken_ff;
   logic [2:0]           rsp_status_ff;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [RegWidth-1:0]  wr_data;
   logic [AW-1:0]        rd_addr;
   logic [RegWidth-1:0]  rd_data;

   logic [CW-1:0]        op_count;
   logic [CW-1:0]        cur_count;
   logic                 admit_ok;
   logic                 release_ok;
   logic                 is_last;
   logic                 is_match;
   logic [RegWidth-1:0]  front_val;
   logic [CW-1:0]        idx_next;

   assign op_ready   = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign op_count   = op.cls ? fcount_ff : gcount_ff;
   assign cur_count  = cur_ff.cls ? fcount_ff : gcount_ff;
   assign idx_next   = CW'(idx_ff) + CW'(1);
   assign is_last    = (idx_next == cur_count);
   assign front_val  = (idx_ff == IW'(0)) ? rd_data : first_ff;

   always_comb begin
      if (op.cls) begin
         admit_ok = (op.reg_num != cfg.scratch_a) && (op.reg_num != cfg.scratch_b);
      end else begin
         admit_ok = cfg.gpr_alloc[op.reg_num];
      end
      admit_ok   = admit_ok && !cfg.excluded[op.reg_num]
                   && ({1'b0, op.reg_num} < 7'(REG_COUNT));
      release_ok = elig_ff[op.reg_num] && ({1'b0, op.reg_num} < 7'(REG_COUNT))
                   && !(op.cls && ({1'b0, op.reg_num} < 7'(FPR_BASE)));
   end

   always_comb begin
      case (cur_ff.mode)
         MODE_CALLER: is_match = !cfg.callee_saved[rd_data];
         MODE_CALLEE: is_match = cfg.callee_saved[rd_data];
         default:     is_match = 1'b1;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {op.cls, op_count[IW-1:0]};
      wr_data = op.reg_num;
      rd_addr = {cur_ff.cls, idx_ff};
      case (state_ff)
         S_IDLE: begin
            wr_en = op_valid && op_ready && (op_count != CW'(LIST_DEPTH))
                    && (((op.kind == OP_ADMIT) && admit_ok)
                        || ((op.kind == OP_RELEASE) && release_ok
                            && (op_count == CW'(0))));
         end
         S_CHK: begin
            wr_addr = {cur_ff.cls, cur_count[IW-1:0]};
            wr_data = cur_ff.reg_num;
            wr_en   = (cur_ff.kind == OP_RELEASE) && (rd_data != cur_ff.reg_num)
                      && is_last && (cur_count != CW'(LIST_DEPTH));
         end
         S_SH_RD: begin
            rd_addr = {cur_ff.cls, idx_next[IW-1:0]};
         end
         S_SH_WR: begin
            wr_en   = 1'b1;
            wr_addr = {cur_ff.cls, idx_ff};
            wr_data = rd_data;
         end
         default: begin
         end
      endcase
   end

   rflp_ram #(
      .WIDTH (RegWidth),
      .DEPTH (2 ** AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         gcount_ff     <= '0;
         fcount_ff     <= '0;
         elig_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (op_valid && op_ready) begin
                  cur_ff        <= op;
                  idx_ff        <= '0;
                  rsp_taken_ff  <= '0;
                  rsp_status_ff <= ST_OK;
                  case (op.kind)
                     OP_CLEAR: begin
                        gcount_ff    <= '0;
                        fcount_ff    <= '0;
                        elig_ff      <= '0;
                        rsp_valid_ff <= 1'b1;
                     end
                     OP_ADMIT: begin
                        rsp_valid_ff <= 1'b1;
                        if (!admit_ok) begin
                           rsp_status_ff <= ST_INELIGIBLE;
                        end else if (op_count == CW'(LIST_DEPTH)) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           elig_ff[op.reg_num] <= 1'b1;
                           if (op.cls) begin
                              fcount_ff <= fcount_ff + CW'(1);
                           end else begin
                              gcount_ff <= gcount_ff + CW'(1);
                           end
                        end
                     end
                     OP_RELEASE: begin
                        if (!release_ok) begin
                           rsp_status_ff <= ST_INELIGIBLE;
                           rsp_valid_ff  <= 1'b1;
                        end else if (op_count == CW'(0)) begin
                           rsp_valid_ff <= 1'b1;
                           if (op.cls) begin
                              fcount_ff <= CW'(1);
                           end else begin
                              gcount_ff <= CW'(1);
                           end
                        end else begin
                           state_ff <= S_RD;
                        end
                     end
                     OP_TAKE: begin
                        if (op_count == CW'(0)) begin
                           rsp_status_ff <= ST_EMPTY;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           state_ff <= S_RD;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_RD: begin
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (idx_ff == IW'(0)) begin
                  first_ff <= rd_data;
               end
               if (cur_ff.kind == OP_RELEASE) begin
                  if (rd_data == cur_ff.reg_num) begin
                     rsp_status_ff <= ST_DUPLICATE;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= S_IDLE;
                  end else if (is_last) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                     if (cur_count == CW'(LIST_DEPTH)) begin
                        rsp_status_ff <= ST_FULL;
                     end else if (cur_ff.cls) begin
                        fcount_ff <= fcount_ff + CW'(1);
                     end else begin
                        gcount_ff <= gcount_ff + CW'(1);
                     end
                  end else begin
                     idx_ff   <= idx_ff + IW'(1);
                     state_ff <= S_RD;
                  end
               end else if (is_match || is_last) begin
                  if (is_match) begin
                     taken_ff <= rd_data;
                  end else begin
                     taken_ff <= front_val;
                     idx_ff   <= '0;
                  end
                  if (is_last && (is_match || (idx_ff == IW'(0)))) begin
                     rsp_taken_ff <= rd_data;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                     if (cur_ff.cls) begin
                        fcount_ff <= fcount_ff - CW'(1);
                     end else begin
                        gcount_ff <= gcount_ff - CW'(1);
                     end
                  end else begin
                     state_ff <= S_SH_RD;
                  end
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_RD;
               end
            end
            S_SH_RD: begin
               state_ff <= S_SH_WR;
            end
            S_SH_WR: begin
               if ((idx_next + CW'(1)) == cur_count) begin
                  rsp_taken_ff <= taken_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
                  if (cur_ff.cls) begin
                     fcount_ff <= fcount_ff - CW'(1);
                  end else begin
                     gcount_ff <= gcount_ff - CW'(1);
                  end
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_SH_RD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_taken_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

### rtl/register_free_list_pool_unit.sv
// Clear, admit, ineligible requests and requests on an empty list are answered
// from the idle state; a take from a list of one entry answers without a shift.
// Release scans the class list one entry at a time, then appends.
// Take scans for the preferred entry and closes the gap by shifting each
// following entry, all through one list RAM port pair.
// Throughput: one request at a time in the list engine; two more queue ahead.
// Reset: synchronous, clears counts, eligibility, queue and configuration.
module register_free_list_pool_unit
   import rflp_pkg::*;
#(
   parameter int LIST_DEPTH = 64,
   parameter int REG_COUNT  = 64,
   parameter int FPR_BASE   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] reg_number, [7:6] zero
   input  logic [3:0]  req_tuser,   // [2:0] cmd, [3] reg_class
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] taken_reg, [7:6] zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    op_valid;
   logic    op_ready;
   op_type  op;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CALLEE_SAVED: cfg_ff.callee_saved <= csr_wdata;
            CSR_GPR_ALLOC:    cfg_ff.gpr_alloc    <= csr_wdata;
            CSR_EXCLUDED:     cfg_ff.excluded     <= csr_wdata;
            CSR_SCRATCH_A:    cfg_ff.scratch_a    <= csr_wdata[RegWidth-1:0];
            CSR_SCRATCH_B:    cfg_ff.scratch_b    <= csr_wdata[RegWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   rflp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op         (op)
   );

   rflp_back #(
      .LIST_DEPTH (LIST_DEPTH),
      .REG_COUNT  (REG_COUNT),
      .FPR_BASE   (FPR_BASE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op         (op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/rflp_checker.sv
module rflp_checker
   import rflp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= ST_FULL) && (rsp_tdata[7:6] == 2'b00))
      else $error("response status out of range");

   a_taken_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[5:0] != 6'd0) |-> (rsp_tuser == ST_OK))
      else $error("taken register with failing status");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind register_free_list_pool_unit rflp_checker u_rflp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
